FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ZCHF_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define ZCHF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/zchf_pkg.sv
// zchf_pkg: widths, step codes and request types of the half-wave fill block
`timescale 1ns / 1ps
package zchf_pkg;

	localparam int COORD_W    = 32;
	localparam int SAMPLE_W   = 16;
	localparam int COUNT_W    = 16;

	localparam int IN_DATA_W  = ((COORD_W + SAMPLE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((COORD_W + SAMPLE_W + COUNT_W + 7) / 8) * 8;

	localparam int QPTR_W     = 1;
	localparam int QDEPTH     = 1 << QPTR_W;
	localparam int DIV_CNT_W  = $clog2(COORD_W + 1);

	// result steps of one item, in output order
	localparam int NSTEP       = 6;
	localparam int STEP_FBASE  = 0;
	localparam int STEP_PREV   = 1;
	localparam int STEP_CROSS  = 2;
	localparam int STEP_LPT    = 3;
	localparam int STEP_LBASE  = 4;
	localparam int STEP_SUM    = 5;

	localparam logic KIND_POINT   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COUNT_W-1:0]         count_t;

	typedef struct packed {
		logic              first;
		logic [NSTEP-1:0]  steps;
		coord_t            x;
		sample_t           y;
		coord_t            px;
		sample_t           py;
	} cmd_t;

	typedef struct packed {
		coord_t  x0;
		sample_t y0;
		coord_t  x1;
		sample_t y1;
	} div_req_t;

	typedef struct packed {
		logic    kind;
		coord_t  x;
		sample_t y;
		count_t  count;
		logic    last;
	} result_t;

	function automatic logic is_selected(sample_t y, logic pol);
		logic neg;
		logic pos;
		neg = y[SAMPLE_W-1];
		pos = !y[SAMPLE_W-1] && (y != '0);
		return pol ? neg : pos;
	endfunction

endpackage

FILE: rtl/zero_crossing_halfwave_fill.sv
// zero_crossing_halfwave_fill: top level of the half-wave polygon fill block
//
//   channel  dir  tdata (low bit up)                    tuser          tlast
//   s_axis   in   sample_x[31:0] sample_y[47:32]        first_sample   last_sample
//   m_axis   out  out_x[31:0] out_y[47:32] count[63:48] result_kind    last_of_item
//   cfg      in   cfg_wr_data = polarity_select         -              -
//
// front takes one sample a cycle while the queue has room; the back pops a queued request once
// the steps of the last one are done and then gives one result a cycle while m_axis is free.
// a crossing comes from a bit-serial unit started at the pop; its result waits while the unit
// is busy, and the previous point goes out in the meantime.
// arst_n clears polarity, previous sample, count, queue and output valid; no clear pass.
// m_axis stalls hold the result register and back up through the queue to s_axis.
`timescale 1ns / 1ps
module zero_crossing_halfwave_fill import zchf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_wr_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // sample_x, sample_y
	input  logic                  s_axis_tuser,   // first_sample
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_x, out_y, point_count
	output logic                  m_axis_tuser,   // result_kind
	output logic                  m_axis_tlast
);

	logic     q_full;
	logic     q_empty;
	logic     push;
	logic     pop;
	cmd_t     push_cmd;
	cmd_t     head;
	logic     div_start;
	logic     div_busy;
	div_req_t div_req;
	coord_t   div_result;
	result_t  res;

	zchf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_x        (s_axis_tdata[COORD_W-1:0]),
		.in_y        (s_axis_tdata[COORD_W +: SAMPLE_W]),
		.in_first    (s_axis_tuser),
		.in_last     (s_axis_tlast),
		.q_full      (q_full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	zchf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	zchf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.req    (div_req),
		.busy   (div_busy),
		.result (div_result)
	);

	zchf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (head),
		.q_pop      (pop),
		.div_start  (div_start),
		.div_req    (div_req),
		.div_busy   (div_busy),
		.div_result (div_result),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (res)
	);

	assign m_axis_tdata = OUT_DATA_W'({res.count, res.y, res.x});
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

endmodule

FILE: rtl/zchf_front.sv
// zchf_front: takes samples, judges selection and builds the result steps
`timescale 1ns / 1ps
module zchf_front import zchf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_wr_en,
	input  logic    cfg_wr_data,
	input  logic    in_valid,
	output logic    in_ready,
	input  coord_t  in_x,
	input  sample_t in_y,
	input  logic    in_first,
	input  logic    in_last,
	input  logic    q_full,
	output logic    push,
	output cmd_t    push_cmd
);

	logic    polarity_q;
	coord_t  prev_x_q;
	sample_t prev_y_q;
	logic    s0;
	logic    s1;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		s0 = is_selected(prev_y_q, polarity_q);
		s1 = is_selected(in_y, polarity_q);
		push_cmd                    = '0;
		push_cmd.first              = in_first;
		push_cmd.x                  = in_x;
		push_cmd.y                  = in_y;
		push_cmd.px                 = prev_x_q;
		push_cmd.py                 = prev_y_q;
		push_cmd.steps[STEP_FBASE]  = in_first && s1 && !in_last;
		push_cmd.steps[STEP_PREV]   = !in_first && s0;
		push_cmd.steps[STEP_CROSS]  = !in_first && (s0 != s1);
		push_cmd.steps[STEP_LPT]    = in_last && s1;
		push_cmd.steps[STEP_LBASE]  = in_last && s1;
		push_cmd.steps[STEP_SUM]    = in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q <= 1'b0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				polarity_q <= cfg_wr_data;
			end
			if (push) begin
				prev_x_q <= in_x;
				prev_y_q <= in_y;
			end
		end
	end

endmodule

FILE: rtl/zchf_queue.sv
// zchf_queue: short queue of step requests between front and back
`timescale 1ns / 1ps
module zchf_queue import zchf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full  = (fill_q == (QPTR_W + 1)'(QDEPTH));
	assign empty = (fill_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/zchf_div.sv
// zchf_div: bit-serial crossing unit, x0 +/- floor(|y0|*|dx|/|y0-y1|)
`timescale 1ns / 1ps
module zchf_div import zchf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  div_req_t req,
	output logic     busy,
	output coord_t   result
);

	logic signed [COORD_W:0]  dx;
	logic signed [SAMPLE_W:0] den;
	logic signed [SAMPLE_W:0] y0_ext;
	logic [COORD_W:0]         adx_full;
	logic [SAMPLE_W:0]        ad_full;
	logic [SAMPLE_W:0]        ay_full;
	logic                     sub_start;

	logic [COORD_W-1:0]       adx_q;
	logic [COORD_W-1:0]       q_q;
	logic [SAMPLE_W-1:0]      r_q;
	logic [SAMPLE_W-1:0]      ay_q;
	logic [SAMPLE_W-1:0]      ad_q;
	coord_t                   x0_q;
	logic                     sub_q;
	logic [DIV_CNT_W-1:0]     cnt_q;
	logic                     busy_q;

	logic [SAMPLE_W+1:0]      t0;
	logic [SAMPLE_W+1:0]      t1;
	logic [SAMPLE_W+1:0]      t2;
	logic [SAMPLE_W+1:0]      ad_ext;
	logic                     ge0;
	logic                     ge1;
	logic [COORD_W-1:0]       q_next;

	assign busy   = busy_q;
	assign result = sub_q ? (x0_q - q_q) : (x0_q + q_q);

	// operand magnitudes and sign of the correction
	always_comb begin
		dx       = {req.x1[COORD_W-1], req.x1} - {req.x0[COORD_W-1], req.x0};
		y0_ext   = {req.y0[SAMPLE_W-1], req.y0};
		den      = y0_ext - {req.y1[SAMPLE_W-1], req.y1};
		adx_full = dx[COORD_W] ? -dx : dx;
		ad_full  = den[SAMPLE_W] ? -den : den;
		ay_full  = y0_ext[SAMPLE_W] ? -y0_ext : y0_ext;
		sub_start = ((req.y0 != '0) && (req.y0[SAMPLE_W-1] != den[SAMPLE_W])) ^ dx[COORD_W];
	end

	// one dividend bit per cycle, quotient digit 0..2 since |y0| <= |den|
	always_comb begin
		ad_ext = {2'b00, ad_q};
		t0     = {1'b0, r_q, 1'b0} + (adx_q[COORD_W-1] ? {2'b00, ay_q} : '0);
		ge0    = (ad_q != '0) && (t0 >= ad_ext);
		t1     = ge0 ? (t0 - ad_ext) : t0;
		ge1    = (ad_q != '0) && (t1 >= ad_ext);
		t2     = ge1 ? (t1 - ad_ext) : t1;
		q_next = {q_q[COORD_W-2:0], 1'b0} + COORD_W'(ge0) + COORD_W'(ge1);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			adx_q <= adx_full[COORD_W-1:0];
			ay_q  <= ay_full[SAMPLE_W-1:0];
			ad_q  <= ad_full[SAMPLE_W-1:0];
			x0_q  <= req.x0;
			sub_q <= sub_start;
			q_q   <= '0;
			r_q   <= '0;
		end else if (busy_q) begin
			adx_q <= {adx_q[COORD_W-2:0], 1'b0};
			q_q   <= q_next;
			r_q   <= t2[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_W'(COORD_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != DIV_CNT_W'(1));
		end
	end

endmodule

FILE: rtl/zchf_back.sv
// zchf_back: walks the steps of each request and drives the result register
`timescale 1ns / 1ps
module zchf_back import zchf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_empty,
	input  cmd_t     q_head,
	output logic     q_pop,
	output logic     div_start,
	output div_req_t div_req,
	input  logic     div_busy,
	input  coord_t   div_result,
	output logic     out_valid,
	input  logic     out_ready,
	output result_t  out_res
);

	cmd_t             cmd_q;
	logic [NSTEP-1:0] pend_q;
	count_t           count_q;
	logic             out_valid_q;
	result_t          out_res_q;

	logic [NSTEP-1:0] pick;
	logic             out_free;
	logic             fire;
	count_t           count_inc;
	result_t          res;

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	assign q_pop     = (pend_q == '0) && !q_empty;
	assign div_start = q_pop && q_head.steps[STEP_CROSS];
	assign div_req   = '{x0: q_head.px, y0: q_head.py, x1: q_head.x, y1: q_head.y};

	always_comb begin
		pick      = pend_q & (~pend_q + NSTEP'(1));
		out_free  = !out_valid_q || out_ready;
		fire      = (pend_q != '0) && out_free && !(pick[STEP_CROSS] && div_busy);
		count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

		res.kind  = pick[STEP_SUM] ? KIND_SUMMARY : KIND_POINT;
		if (pick[STEP_PREV]) begin
			res.x = cmd_q.px;
		end else if (pick[STEP_CROSS]) begin
			res.x = div_result;
		end else if (pick[STEP_SUM]) begin
			res.x = '0;
		end else begin
			res.x = cmd_q.x;
		end
		if (pick[STEP_PREV]) begin
			res.y = cmd_q.py;
		end else if (pick[STEP_LPT]) begin
			res.y = cmd_q.y;
		end else begin
			res.y = '0;
		end
		res.count = pick[STEP_SUM] ? count_q : count_inc;
		res.last  = ((pend_q & ~pick) == '0);
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_head;
		end
		if (fire) begin
			out_res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				pend_q <= q_head.steps;
				if (q_head.first) begin
					count_q <= '0;
				end
			end else if (fire) begin
				pend_q <= pend_q & ~pick;
				if (!pick[STEP_SUM]) begin
					count_q <= count_inc;
				end
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/zchf_checker.sv
// zchf_checker: port-level checks on the result stream, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module zchf_checker import zchf_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser,
	input logic                  m_axis_tlast
);

	`ZCHF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")
	`ZCHF_ASSERT_IMPLY(a_sum_last, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY), m_axis_tlast, "summary not last of item")
	`ZCHF_ASSERT_IMPLY(a_sum_zero, m_axis_tvalid && (m_axis_tuser == KIND_SUMMARY), m_axis_tdata[COORD_W+SAMPLE_W-1:0] == '0, "summary carries a point")
	`ZCHF_ASSERT_IMPLY(a_point_cnt, m_axis_tvalid && (m_axis_tuser == KIND_POINT), m_axis_tdata[COORD_W+SAMPLE_W +: COUNT_W] != '0, "point with zero count")

endmodule

bind zero_crossing_halfwave_fill zchf_checker u_zchf_checker (.*);
